// ===== rtl/core/legendre_polynomial_eval_macros.svh =====
// Assertion macros for the Legendre polynomial evaluator.
`ifndef LEGENDRE_POLYNOMIAL_EVAL_MACROS_SVH
`define LEGENDRE_POLYNOMIAL_EVAL_MACROS_SVH
`ifndef SYNTHESIS
`define LPE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define LPE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPE_ASSERT_IMP(lbl, ante, cons, msg)
`define LPE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/lpe_pkg.sv =====
// Shared types and constants of the Legendre polynomial evaluator.
`default_nettype none
package lpe_pkg;

  localparam int FRAC_BITS     = 30;
  localparam int MAX_ORDER_DEF = 31;

  localparam int ORDER_W = 5;
  localparam int POINT_W = 32;
  localparam int VALUE_W = 32;
  localparam int SLOPE_W = 42;

  localparam int CUR_W  = 34;
  localparam int XMAG_W = 31;
  localparam int PROD_W = XMAG_W + CUR_W - 1;
  localparam int MQ_W   = PROD_W - FRAC_BITS;

  localparam int DIG = 8;
  localparam int NDW = 40;
  localparam int NMW = 38;
  localparam int DVW = NMW + FRAC_BITS;
  localparam int DSW = FRAC_BITS + 1;
  localparam int QW  = SLOPE_W;

  localparam logic signed [POINT_W-1:0] ONE_P = POINT_W'(64'd1 << FRAC_BITS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_COMB,
    S_DST,
    S_DIV,
    S_FXX,
    S_FXC,
    S_FNUM,
    S_FDST,
    S_FDIV,
    S_DONE
  } lpe_state_t;

  typedef struct packed {
    logic start;
    logic wide;
  } lpe_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } lpe_div_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/lpe_if.sv =====
// Valid/ready channel interfaces for the input items and the results.
`default_nettype none
interface lpe_in_if import lpe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [ORDER_W-1:0]         order;
  logic signed [POINT_W-1:0]  point;

  modport source(output valid, order, point, input ready);
  modport sink(input valid, order, point, output ready);
endinterface

interface lpe_out_if import lpe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  value;
  logic signed [SLOPE_W-1:0]  slope;
  logic                       endpoint_flag;

  modport source(output valid, value, slope, endpoint_flag, input ready);
  modport sink(input valid, value, slope, endpoint_flag, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lpe_div.sv =====
// Shared restoring divider: eight quotient bits a cycle for small divisors, one for wide ones.
`default_nettype none
module lpe_div import lpe_pkg::*; #(
  parameter int KW = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  lpe_div_req_t      req,
  input  logic [DVW-1:0]    dividend,
  input  logic [DSW-1:0]    divisor,
  output lpe_div_stat_t     stat,
  output logic [QW-1:0]     quo,
  output logic [DSW-1:0]    rem
);

  localparam int CNT_W = $clog2(DVW + 1);
  localparam int NCYC  = NDW / DIG;

  logic             busy;
  logic             done;
  logic             wide;
  logic [CNT_W-1:0] cnt;
  logic [DVW-1:0]   dvd;
  logic [DSW-1:0]   dsr;
  logic             ovf;

  logic [KW-1:0]    nrem;
  logic [KW:0]      nwork;
  logic [DIG-1:0]   nbits;
  logic [DSW:0]     wwork;
  logic             wfit;
  logic [DSW-1:0]   wrem;

  always_comb begin
    nrem  = rem[KW-1:0];
    nwork = '0;
    nbits = '0;
    for (int i = 0; i < DIG; i++) begin
      nwork = {nrem, dvd[DVW-1-i]};
      if (nwork >= {1'b0, dsr[KW-1:0]}) begin
        nrem             = KW'(nwork - {1'b0, dsr[KW-1:0]});
        nbits[DIG-1-i]   = 1'b1;
      end else begin
        nrem             = nwork[KW-1:0];
        nbits[DIG-1-i]   = 1'b0;
      end
    end
  end

  always_comb begin
    wwork = {rem, dvd[DVW-1]};
    wfit  = (wwork >= {1'b0, dsr});
    wrem  = wfit ? DSW'(wwork - {1'b0, dsr}) : wwork[DSW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.wide ? CNT_W'(DVW) : CNT_W'(NCYC);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      wide <= req.wide;
      dvd  <= dividend;
      dsr  <= divisor;
      rem  <= '0;
      quo  <= '0;
      ovf  <= 1'b0;
    end else if (busy) begin
      if (wide) begin
        dvd <= dvd << 1;
        rem <= wrem;
        quo <= {quo[QW-2:0], wfit};
        ovf <= ovf | quo[QW-1];
      end else begin
        dvd <= dvd << DIG;
        rem <= DSW'(nrem);
        quo <= {quo[QW-DIG-1:0], nbits};
        ovf <= ovf | (|quo[QW-1 -: DIG]);
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.ovf  = ovf;

endmodule
`default_nettype wire

// ===== rtl/core/legendre_polynomial_eval.sv =====
// Legendre polynomial evaluator top level: sequencer, shared multiplier and result register.
//
// Takes an order n and a point x (signed Q1.30, clamped to [-1,1]) and returns P_n(x) in
// Q1.30, the derivative in saturating Q11.30, and a flag when |x| = 1 leaves the derivative
// undefined (derivative then reads 0). One item is worked at a time; the input is ready
// again as soon as the result sits in the output register.
// For n >= 2 each recurrence step makes one pass through the shared multiplier, the
// coefficient combine, and a division by k in the eight-bit-per-cycle mode of the
// divider; the derivative adds a one-bit-per-cycle pass of the same divider; an
// endpoint point skips that division.
`default_nettype none
`include "legendre_polynomial_eval_macros.svh"
module legendre_polynomial_eval import lpe_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lpe_in_if.sink      item,
  lpe_out_if.source   result
);

  localparam int KW = $clog2(MAX_ORDER + 1);
  localparam int CW = KW + 1;
  localparam int TW = MQ_W + KW + 3;
  localparam int DW = MQ_W + 2;
  localparam int NW = DW + KW + 1;

  localparam logic signed [CUR_W-1:0] ONE_C = CUR_W'(ONE_P);

  lpe_state_t state, state_next;

  logic [KW-1:0]              n;
  logic [KW-1:0]              k;
  logic signed [POINT_W-1:0]  x;
  logic signed [CUR_W-1:0]    cur;
  logic signed [CUR_W-1:0]    prev;
  logic [PROD_W-1:0]          prod;
  logic                       prod_neg;
  logic [NDW-1:0]             tdiv;
  logic                       tneg;
  logic [DSW-1:0]             den;
  logic [NMW-1:0]             nmag;
  logic                       nneg;
  logic [SLOPE_W-1:0]         slope;
  logic                       flag;

  logic                       out_valid;
  logic signed [VALUE_W-1:0]  out_value;
  logic signed [SLOPE_W-1:0]  out_slope;
  logic                       out_flag;

  logic                       in_ready;
  logic                       out_load;
  logic signed [POINT_W-1:0]  x_in;
  logic [KW-1:0]              n_in;
  logic [XMAG_W-1:0]          xmag;
  logic [CUR_W-2:0]           curmag;
  logic [CUR_W-2:0]           mul_b;
  logic                       mul_neg;
  logic [PROD_W-1:0]          prod_mul;
  logic [PROD_W-1:0]          mq_sum;
  logic [MQ_W-1:0]            mq_mag;
  logic signed [MQ_W:0]       mq;
  logic [CW-1:0]              c1;
  logic [KW-1:0]              c2;
  logic signed [TW-1:0]       t;
  logic [TW-1:0]              tmag;
  logic signed [CUR_W-1:0]    cur_q;
  logic [DSW-1:0]             den_calc;
  logic signed [DW-1:0]       diff;
  logic signed [NW-1:0]       num;
  logic                       rnd;
  logic [QW:0]                qr;
  logic [QW:0]                cap;
  logic [QW:0]                qf;
  logic [SLOPE_W-1:0]         slope_wide;
  logic signed [VALUE_W-1:0]  val_clamp;

  lpe_div_req_t               dreq;
  lpe_div_stat_t              dstat;
  logic [DVW-1:0]             ddvd;
  logic [DSW-1:0]             ddsr;
  logic [QW-1:0]              dquo;
  logic [DSW-1:0]             drem;

  lpe_div #(
    .KW (KW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (dreq),
    .dividend (ddvd),
    .divisor  (ddsr),
    .stat     (dstat),
    .quo      (dquo),
    .rem      (drem)
  );

  always_comb begin
    if (item.point > ONE_P) begin
      x_in = ONE_P;
    end else if (item.point < -ONE_P) begin
      x_in = -ONE_P;
    end else begin
      x_in = item.point;
    end
    if (32'(item.order) > 32'(MAX_ORDER)) begin
      n_in = KW'(MAX_ORDER);
    end else begin
      n_in = KW'(item.order);
    end
  end

  always_comb begin
    xmag     = x[POINT_W-1] ? XMAG_W'(-x) : XMAG_W'(x);
    curmag   = cur[CUR_W-1] ? (CUR_W-1)'(-cur) : (CUR_W-1)'(cur);
    mul_b    = (state == S_FXX) ? (CUR_W-1)'(xmag) : curmag;
    mul_neg  = (state == S_FXX) ? 1'b0 : (x[POINT_W-1] ^ cur[CUR_W-1]);
    prod_mul = PROD_W'(xmag) * PROD_W'(mul_b);

    mq_sum = prod + (PROD_W'(1) << (FRAC_BITS - 1));
    mq_mag = mq_sum[PROD_W-1:FRAC_BITS];
    mq     = prod_neg ? -$signed({1'b0, mq_mag}) : $signed({1'b0, mq_mag});

    c1   = {k, 1'b0} - CW'(1);
    c2   = k - KW'(1);
    t    = TW'($signed({1'b0, c1})) * TW'(mq) - TW'($signed({1'b0, c2})) * TW'(prev);
    tmag = t[TW-1] ? TW'(-t) : TW'(t);

    cur_q = tneg ? -CUR_W'(dquo) : CUR_W'(dquo);

    den_calc = DSW'(MQ_W'(1) << FRAC_BITS) - DSW'(mq_mag);
    diff     = DW'(prev) - DW'(mq);
    num      = NW'($signed({1'b0, n})) * NW'(diff);

    rnd        = ({drem, 1'b0} >= {1'b0, den});
    qr         = (QW+1)'(dquo) + (QW+1)'(rnd);
    cap        = nneg ? ((QW+1)'(1) << (SLOPE_W - 1))
                      : (((QW+1)'(1) << (SLOPE_W - 1)) - (QW+1)'(1));
    qf         = (dstat.ovf || (qr > cap)) ? cap : qr;
    slope_wide = nneg ? SLOPE_W'(-qf) : SLOPE_W'(qf);

    if (cur > ONE_C) begin
      val_clamp = ONE_P;
    end else if (cur < -ONE_C) begin
      val_clamp = -ONE_P;
    end else begin
      val_clamp = VALUE_W'(cur);
    end

    if (state == S_FDST) begin
      ddvd = {nmag, {FRAC_BITS{1'b0}}};
      ddsr = den;
    end else begin
      ddvd = {tdiv, {(DVW-NDW){1'b0}}};
      ddsr = DSW'(k);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item.valid) begin
          state_next = (n_in < KW'(2)) ? S_DONE : S_MUL;
        end
      end
      S_MUL:  state_next = S_COMB;
      S_COMB: state_next = S_DST;
      S_DST:  state_next = S_DIV;
      S_DIV: begin
        if (dstat.done) begin
          state_next = (k == n) ? S_FXX : S_MUL;
        end
      end
      S_FXX:  state_next = S_FXC;
      S_FXC:  state_next = S_FNUM;
      S_FNUM: state_next = (den == '0) ? S_DONE : S_FDST;
      S_FDST: state_next = S_FDIV;
      S_FDIV: begin
        if (dstat.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || result.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_load   = 1'b0;
    dreq.start = 1'b0;
    dreq.wide  = 1'b0;
    case (state)
      S_IDLE: in_ready = 1'b1;
      S_DST:  dreq.start = 1'b1;
      S_FDST: begin
        dreq.start = 1'b1;
        dreq.wide  = 1'b1;
      end
      S_DONE: out_load = !out_valid || result.ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (item.valid) begin
          x     <= x_in;
          n     <= n_in;
          k     <= KW'(2);
          cur   <= (n_in == '0) ? ONE_C : CUR_W'(x_in);
          prev  <= ONE_C;
          slope <= (n_in == KW'(1)) ? SLOPE_W'(ONE_P) : '0;
          flag  <= 1'b0;
        end
      end
      S_MUL, S_FXX: begin
        prod     <= prod_mul;
        prod_neg <= mul_neg;
      end
      S_COMB: begin
        tdiv <= NDW'(tmag + TW'(k >> 1));
        tneg <= t[TW-1];
      end
      S_DIV: begin
        if (dstat.done) begin
          prev <= cur;
          cur  <= cur_q;
          if (k != n) begin
            k <= k + KW'(1);
          end
        end
      end
      S_FXC: begin
        den      <= den_calc;
        prod     <= prod_mul;
        prod_neg <= mul_neg;
      end
      S_FNUM: begin
        nmag <= num[NW-1] ? NMW'(-num) : NMW'(num);
        nneg <= num[NW-1];
        if (den == '0) begin
          flag  <= 1'b1;
          slope <= '0;
        end
      end
      S_FDIV: begin
        if (dstat.done) begin
          slope <= slope_wide;
        end
      end
      default: begin
        if (out_load) begin
          out_value <= val_clamp;
          out_slope <= slope;
          out_flag  <= flag;
        end
      end
    endcase
  end

  assign item.ready           = in_ready;
  assign result.valid         = out_valid;
  assign result.value         = out_value;
  assign result.slope         = out_slope;
  assign result.endpoint_flag = out_flag;

  `LPE_ASSERT_IMP(a_div_idle_start, dreq.start, !dstat.busy, "divider started while busy")
  `LPE_ASSERT_IMP(a_div_done_wait, dstat.done, state == S_DIV || state == S_FDIV, "stray divider done")
  `LPE_ASSERT_NXT(a_hold_result, (state == S_DONE) && result.valid && !result.ready, state == S_DONE, "result dropped while output stalled")
  `LPE_ASSERT_IMP(a_flag_slope, result.valid && result.endpoint_flag, result.slope == '0, "endpoint with nonzero slope")

endmodule
`default_nettype wire

// ===== bench/tb_legendre_polynomial_eval.sv =====
// Self-checking testbench for the Legendre polynomial evaluator.
`timescale 1ns / 100ps
module tb_legendre_polynomial_eval;
  import lpe_pkg::*;

  localparam longint ONE_Q = 64'sd1 << FRAC_BITS;
  localparam longint unsigned MAG_CAP = 64'd1 << 62;
  localparam longint unsigned SLOPE_POS_CAP = (64'd1 << 41) - 1;
  localparam longint unsigned SLOPE_NEG_CAP = 64'd1 << 41;
  localparam int LONG_STALL = 600;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PER_PHASE = 390;

  typedef struct packed {
    logic [ORDER_W-1:0]        order;
    logic signed [POINT_W-1:0] point;
  } eval_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [SLOPE_W-1:0] slope;
    logic                      endpoint_flag;
  } legendre_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lpe_in_if  in_ch ();
  lpe_out_if out_ch ();

  legendre_polynomial_eval u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (in_ch),
    .result (out_ch)
  );

  eval_req_t        eval_requests[$];
  legendre_result_t predicted_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int long_stall_asks = 0;
  int long_stall_seen;
  int stall_left;
  int quiet_cycles;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned mag_of(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint signed_mag(input longint unsigned m, input bit neg);
    if (m > MAG_CAP) m = MAG_CAP;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // Fixed-point product, rounded to nearest with ties away from zero.
  function automatic longint fx_mul(input longint a, input longint b);
    logic [127:0] prod;
    longint unsigned r;
    prod = 128'(mag_of(a)) * 128'(mag_of(b)) + (128'd1 << (FRAC_BITS - 1));
    if ((prod >> (64 + FRAC_BITS)) != 0) r = MAG_CAP;
    else r = 64'(prod >> FRAC_BITS);
    return signed_mag(r, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_div_k(input longint num, input int k);
    longint unsigned kk;
    kk = longint'(k);
    return signed_mag((mag_of(num) + kk / 2) / kk, num < 0);
  endfunction

  // Quotient in Q11.30 with rounding and saturation; den is positive.
  function automatic longint fx_div_slope(input longint num, input longint den);
    longint unsigned m, d, cap, q;
    logic [127:0] wide, q_wide, rem;
    m = mag_of(num);
    d = den;
    cap = (num < 0) ? SLOPE_NEG_CAP : SLOPE_POS_CAP;
    if (m / d > (cap >> FRAC_BITS)) begin
      q = cap;
    end else begin
      wide = 128'(m) << FRAC_BITS;
      q_wide = wide / 128'(d);
      rem = wide % 128'(d);
      if ((rem << 1) >= 128'(d)) q_wide = q_wide + 1;
      q = (q_wide > 128'(cap)) ? cap : 64'(q_wide);
    end
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic legendre_result_t legendre_eval(input logic [ORDER_W-1:0] order,
                                                      input logic signed [POINT_W-1:0] point);
    legendre_result_t res;
    longint x, prev, cur, t, val, slope, den;
    int n;
    bit flag;
    n = order;
    if (n > MAX_ORDER_DEF) n = MAX_ORDER_DEF;
    x = point;
    if (x > ONE_Q) x = ONE_Q;
    if (x < -ONE_Q) x = -ONE_Q;
    if (n == 0) begin
      prev = 0;
      cur = ONE_Q;
    end else begin
      prev = ONE_Q;
      cur = x;
      for (int k = 2; k <= n; k++) begin
        t = longint'(2 * k - 1) * fx_mul(x, cur) - longint'(k - 1) * prev;
        t = fx_div_k(t, k);
        prev = cur;
        cur = t;
      end
    end
    val = cur;
    if (val > ONE_Q) val = ONE_Q;
    if (val < -ONE_Q) val = -ONE_Q;
    slope = 0;
    flag = 1'b0;
    if (n == 1) begin
      slope = ONE_Q;
    end else if (n >= 2) begin
      den = ONE_Q - fx_mul(x, x);
      if (den <= 0) flag = 1'b1;
      else slope = fx_div_slope(longint'(n) * (prev - fx_mul(x, cur)), den);
    end
    res.value = VALUE_W'(val);
    res.slope = SLOPE_W'(slope);
    res.endpoint_flag = flag;
    return res;
  endfunction

  task automatic queue_eval(input int order, input longint point);
    eval_req_t req;
    req.order = ORDER_W'(order);
    req.point = POINT_W'(point);
    eval_requests.push_back(req);
  endtask

  task automatic queue_random_evals(input int count);
    int order;
    longint point, sgn;
    for (int i = 0; i < count; i++) begin
      order = ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom_range(31);
      sgn = $urandom_range(1) ? 1 : -1;
      case ($urandom_range(9))
        0: point = sgn * ONE_Q;
        1: point = sgn * (ONE_Q - $urandom_range(1000));
        2: point = $urandom();
        3: point = sgn * (ONE_Q + 1 + $urandom_range(1000));
        default: point = longint'($urandom_range(32'h8000_0000, 0)) - ONE_Q;
      endcase
      queue_eval(order, point);
    end
  endtask

  task automatic wait_for_drain();
    while (eval_requests.size() != 0 || in_ch.valid || predicted_results.size() != 0)
      @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_items
    eval_req_t req;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.order <= '0;
      in_ch.point <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        predicted_results.push_back(legendre_eval(in_ch.order, in_ch.point));
      if (!in_ch.valid || in_ch.ready) begin
        if (eval_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = eval_requests.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.order <= req.order;
          in_ch.point <= req.point;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    legendre_result_t exp_r;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
      long_stall_seen <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result beat: value %h, slope %h, flag %b", $time,
                   out_ch.value, out_ch.slope, out_ch.endpoint_flag);
          errors++;
        end else begin
          exp_r = predicted_results.pop_front();
          if (out_ch.value !== exp_r.value) begin
            $display("%0t: value mismatch: expected %h, actual %h", $time,
                     exp_r.value, out_ch.value);
            errors++;
          end
          if (out_ch.slope !== exp_r.slope) begin
            $display("%0t: slope mismatch: expected %h, actual %h", $time,
                     exp_r.slope, out_ch.slope);
            errors++;
          end
          if (out_ch.endpoint_flag !== exp_r.endpoint_flag) begin
            $display("%0t: endpoint_flag mismatch: expected %b, actual %b", $time,
                     exp_r.endpoint_flag, out_ch.endpoint_flag);
            errors++;
          end
        end
      end
      if (long_stall_asks != long_stall_seen) begin
        long_stall_seen <= long_stall_asks;
        stall_left <= LONG_STALL;
        out_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Field extremes, endpoints, clamped points and points just inside the endpoints.
    queue_eval(0, 0);
    queue_eval(0, -ONE_Q);
    queue_eval(1, -ONE_Q);
    queue_eval(1, ONE_Q);
    queue_eval(2, 0);
    queue_eval(2, ONE_Q);
    queue_eval(31, -ONE_Q);
    queue_eval(31, ONE_Q);
    queue_eval(31, 0);
    queue_eval(5, ONE_Q - 1);
    queue_eval(5, -(ONE_Q - 1));
    queue_eval(31, ONE_Q - 1);
    queue_eval(31, 32'h7FFF_FFFF);
    queue_eval(30, -64'sd2147483648);
    queue_eval(31, ONE_Q + 1);
    queue_eval(3, ONE_Q / 2);
    queue_eval(4, -ONE_Q / 2);
    queue_eval(17, ONE_Q);
    queue_eval(2, 1);
    queue_eval(10, -1);
    queue_eval(31, -(ONE_Q - 1));

    queue_random_evals(20);
    long_stall_asks = long_stall_asks + 1;
    queue_random_evals(RANDOM_PER_PHASE - 30);
    wait_for_drain();

    for (int phase = 1; phase <= 3; phase++) begin
      case (phase)
        1: begin send_idle_pct = 74; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 74; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      queue_random_evals(RANDOM_PER_PHASE);
      wait_for_drain();
    end

    repeat (400) @(posedge clk);
    if (errors == 0 && predicted_results.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
